/* src/psgva_pkg.sv */
// Shared types, codes and the tone period table of the voice allocator.
package psgva_pkg;

  typedef enum logic [1:0] {
    KIND_KEY_ON  = 2'd0,
    KIND_KEY_OFF = 2'd1,
    KIND_EXPR    = 2'd2,
    KIND_BEND    = 2'd3
  } kind_t;

  // Channel whose key-ons are ignored (percussion channel).
  localparam logic [7:0] DRUM_CHANNEL = 8'd9;

  // Bias that maps the signed bend word onto 0..16383.
  localparam logic [13:0] BEND_BIAS = 14'h2000;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    kind_t              kind;
    logic [15:0]        voice_id;
    logic [6:0]         note;
    logic [6:0]         velocity;
    logic [6:0]         expression;
    logic signed [13:0] bend;
  } item_t;

  // Handshake between the front queue and the engine.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef struct packed {
    logic       chip;
    logic [3:0] register_index;
    logic [7:0] write_data;
    logic       last;
  } write_t;

  localparam logic [11:0] PERIOD_TABLE [128] = '{
    12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
    12'd4095, 12'd4095, 12'd4095, 12'd4081, 12'd3852, 12'd3636, 12'd3432, 12'd3239,
    12'd3057, 12'd2886, 12'd2724, 12'd2571, 12'd2427, 12'd2290, 12'd2162, 12'd2040,
    12'd1926, 12'd1818, 12'd1716, 12'd1619, 12'd1528, 12'd1443, 12'd1362, 12'd1285,
    12'd1213, 12'd1145, 12'd1081, 12'd1020, 12'd963,  12'd909,  12'd858,  12'd809,
    12'd764,  12'd721,  12'd681,  12'd642,  12'd606,  12'd572,  12'd540,  12'd510,
    12'd481,  12'd454,  12'd429,  12'd404,  12'd382,  12'd360,  12'd340,  12'd321,
    12'd303,  12'd286,  12'd270,  12'd255,  12'd240,  12'd227,  12'd214,  12'd202,
    12'd191,  12'd180,  12'd170,  12'd160,  12'd151,  12'd143,  12'd135,  12'd127,
    12'd120,  12'd113,  12'd107,  12'd101,  12'd95,   12'd90,   12'd85,   12'd80,
    12'd75,   12'd71,   12'd67,   12'd63,   12'd60,   12'd56,   12'd53,   12'd50,
    12'd47,   12'd45,   12'd42,   12'd40,   12'd37,   12'd35,   12'd33,   12'd31,
    12'd30,   12'd28,   12'd26,   12'd25,   12'd23,   12'd22,   12'd21,   12'd20,
    12'd18,   12'd17,   12'd16,   12'd15,   12'd15,   12'd14,   12'd13,   12'd12,
    12'd11,   12'd11,   12'd10,   12'd10,   12'd9,    12'd8,    12'd8,    12'd7,
    12'd7,    12'd7,    12'd6,    12'd6,    12'd5,    12'd5,    12'd5,    12'd5
  };

endpackage

/* src/psgva_in_if.sv */
// Note event channel: valid/ready handshake with the event fields.
interface psgva_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [15:0]        voice_id;
  logic [6:0]         note;
  logic [6:0]         velocity;
  logic [6:0]         expression;
  logic signed [13:0] bend;

  modport source (output valid, kind, voice_id, note, velocity, expression, bend,
                  input ready);
  modport sink   (input valid, kind, voice_id, note, velocity, expression, bend,
                  output ready);
endinterface

/* src/psgva_out_if.sv */
// Register write channel: valid/ready handshake with one chip write.
interface psgva_out_if;
  logic       valid;
  logic       ready;
  logic       chip;
  logic [3:0] register_index;
  logic [7:0] write_data;
  logic       last;

  modport source (output valid, chip, register_index, write_data, last, input ready);
  modport sink   (input valid, chip, register_index, write_data, last, output ready);
endinterface

/* src/psgva_front.sv */
// Front end: accepts note events, drops drum-channel key-ons, queues the rest.
module psgva_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  psgva_pkg::item_t        in_item,
  output psgva_pkg::queue_head_t  head,
  input  logic                    head_pop
);
  import psgva_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  item_t          slot_r [QUEUE_DEPTH];
  logic [AW-1:0]  wptr_r, rptr_r;
  logic [CW-1:0]  fill_r;
  logic           take, drop, push, pop;

  assign in_ready = (fill_r != CW'(QUEUE_DEPTH));
  assign take     = in_valid && in_ready;
  // drum-channel key-ons produce nothing: accept and drop the beat
  assign drop     = (in_item.kind == KIND_KEY_ON) && (in_item.voice_id[7:0] == DRUM_CHANNEL);
  assign push     = take && !drop;
  assign pop      = head_pop && (fill_r != '0);

  assign head.valid = (fill_r != '0);
  assign head.item  = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      fill_r <= fill_r + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= in_item;
    end
  end

endmodule

/* src/psgva_engine.sv */
// Back end: voice lookup, allocation, list upkeep and register write sequencing.
module psgva_engine #(
  parameter int unsigned VOICES          = 6,
  parameter int unsigned VOICES_PER_CHIP = 3,
  parameter int unsigned FRACTION_BITS   = 7
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  psgva_pkg::queue_head_t head,
  output logic                   head_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output psgva_pkg::write_t      out_write
);
  import psgva_pkg::*;

  localparam int unsigned VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned CW = $clog2(VOICES + 1);
  localparam int unsigned F  = FRACTION_BITS;
  localparam int unsigned PW = F + 13;
  localparam int unsigned SEMI_BIAS = 8192 >> FRACTION_BITS;

  typedef enum logic [11:0] {
    ST_IDLE    = 12'b000000000001,
    ST_DECODE  = 12'b000000000010,
    ST_FINDPOS = 12'b000000000100,
    ST_INSERT  = 12'b000000001000,
    ST_STORE   = 12'b000000010000,
    ST_TONE_A  = 12'b000000100000,
    ST_TONE_B  = 12'b000001000000,
    ST_LO      = 12'b000010000000,
    ST_HI      = 12'b000100000000,
    ST_VOL     = 12'b001000000000,
    ST_SCAN    = 12'b010000000000,
    ST_FINISH  = 12'b100000000000
  } state_t;

  state_t         st_r, st_nxt;
  item_t          cur_r;
  logic [VW-1:0]  v_r;
  logic [CW-1:0]  pos_r, cnt_r, fcnt_r;
  logic [VOICES-1:0] act_r;

  logic [15:0]    ident_r [VOICES];
  logic [6:0]     vel_r   [VOICES];
  logic [6:0]     expr_r  [VOICES];
  logic [5:0]     prio_r  [VOICES];
  logic [6:0]     note_r  [VOICES];
  logic [VW-1:0]  order_r [VOICES];
  logic [VW-1:0]  fstack_r[VOICES];

  logic [11:0]    pa_r, pb_r;
  logic [F-1:0]   det_r;
  logic [PW-1:0]  prod_a_r, prod_b_r;
  logic [7:0]     dp_hi_r;

  logic           pend_valid_r, out_valid_r;
  write_t         pend_r, out_r;

  // per-voice chip select and channel, fixed at elaboration
  logic           voice_chip [VOICES];
  logic [1:0]     voice_ch   [VOICES];

  for (genvar g = 0; g < VOICES; g++) begin : g_map
    assign voice_chip[g] = 1'((g / VOICES_PER_CHIP) % 2);
    assign voice_ch[g]   = 2'(g % VOICES_PER_CHIP);
  end

  // key lookup over all voices in parallel; active identities are unique
  logic [VOICES-1:0] hit_vec;
  logic              hit_any;
  logic [VW-1:0]     hit_idx;
  logic [VW-1:0]     opos;
  logic [5:0]        prio_new;
  logic [13:0]       prio_prod;
  logic              pos_adv;
  logic [VW-1:0]     scan_v;
  logic              scan_hit;

  always_comb begin
    hit_vec = '0;
    hit_any = 1'b0;
    hit_idx = '0;
    opos    = '0;
    for (int i = 0; i < VOICES; i++) begin
      hit_vec[i] = act_r[i] && (ident_r[i] == cur_r.voice_id);
    end
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_any = 1'b1;
        hit_idx = VW'(i);
      end
    end
    for (int i = VOICES - 1; i >= 0; i--) begin
      if ((CW'(i) < cnt_r) && (order_r[i] == hit_idx)) begin
        opos = VW'(i);
      end
    end
  end

  assign prio_prod = cur_r.velocity * cur_r.expression;
  assign prio_new  = prio_prod[13:8];
  assign scan_v    = order_r[pos_r[VW-1:0]];
  assign pos_adv   = (pos_r < cnt_r) && (prio_new >= prio_r[scan_v]);
  assign scan_hit  = (ident_r[scan_v][7:0] == cur_r.voice_id[7:0]);

  // pitch: index and neighbor from the bend, then interpolate
  logic [13:0]        biased;
  logic signed [15:0] idx_s;
  logic [6:0]         idx, nb;
  logic [F:0]         wa;
  logic [F+15:0]      dsum;
  logic [15:0]        dp;
  logic [13:0]        vol_prod;

  always_comb begin
    biased = cur_r.bend ^ BEND_BIAS;
    idx_s  = $signed({9'b0, note_r[v_r]}) + $signed(16'(biased >> F)) - 16'(SEMI_BIAS);
    if (idx_s < 0) begin
      idx = '0;
    end else if (idx_s > 16'sd127) begin
      idx = 7'd127;
    end else begin
      idx = idx_s[6:0];
    end
    nb   = (idx == 7'd127) ? idx : idx + 7'd1;
    wa   = (F+1)'(1 << F) - (F+1)'(det_r);
    dsum = (F+16)'(prod_a_r) + (F+16)'(prod_b_r);
    dp   = 16'(dsum >> F);
  end

  assign vol_prod = vel_r[v_r] * expr_r[v_r];

  // write staging: one write is held back so the final one can carry last
  logic   out_room, can_emit, emit_vld, emit_fire, mv_out, mv_last;
  write_t emit_w;

  assign out_room = !out_valid_r || out_ready;
  assign can_emit = !pend_valid_r || out_room;

  always_comb begin
    emit_vld                 = 1'b0;
    emit_w.chip              = voice_chip[v_r];
    emit_w.register_index    = 4'({voice_ch[v_r], 1'b0});
    emit_w.write_data        = dp[7:0];
    emit_w.last              = 1'b0;
    unique case (st_r)
      ST_LO: begin
        emit_vld = 1'b1;
      end
      ST_HI: begin
        emit_vld              = 1'b1;
        emit_w.register_index = 4'({voice_ch[v_r], 1'b1});
        emit_w.write_data     = dp_hi_r;
      end
      ST_VOL: begin
        emit_vld              = 1'b1;
        emit_w.register_index = 4'({2'b10, voice_ch[v_r]});
        emit_w.write_data     = (cur_r.kind == KIND_KEY_OFF) ? 8'd0 : 8'(vol_prod[13:10]);
      end
      default: ;
    endcase
  end

  assign emit_fire = emit_vld && can_emit;
  assign mv_last   = (st_r == ST_FINISH) && pend_valid_r && out_room;
  assign mv_out    = (emit_fire && pend_valid_r) || mv_last;
  assign head_pop  = (st_r == ST_IDLE) && head.valid;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:    if (head.valid) st_nxt = ST_DECODE;
      ST_DECODE: begin
        unique case (cur_r.kind)
          KIND_KEY_ON: begin
            if (hit_any) st_nxt = ST_STORE;
            else if (fcnt_r != '0 || cnt_r != '0) st_nxt = ST_FINDPOS;
            else st_nxt = ST_FINISH;
          end
          KIND_KEY_OFF: st_nxt = hit_any ? ST_VOL : ST_FINISH;
          default:      st_nxt = ST_SCAN;
        endcase
      end
      ST_FINDPOS: if (!pos_adv) st_nxt = ST_INSERT;
      ST_INSERT:  st_nxt = ST_STORE;
      ST_STORE:   st_nxt = ST_TONE_A;
      ST_TONE_A:  st_nxt = ST_TONE_B;
      ST_TONE_B:  st_nxt = ST_LO;
      ST_LO:      if (can_emit) st_nxt = ST_HI;
      ST_HI:      if (can_emit) st_nxt = (cur_r.kind == KIND_BEND) ? ST_SCAN : ST_VOL;
      ST_VOL:     if (can_emit) st_nxt = (cur_r.kind == KIND_EXPR) ? ST_SCAN : ST_FINISH;
      ST_SCAN: begin
        if (pos_r >= cnt_r) st_nxt = ST_FINISH;
        else if (scan_hit) st_nxt = (cur_r.kind == KIND_EXPR) ? ST_VOL : ST_TONE_A;
      end
      ST_FINISH:  if (!pend_valid_r || out_room) st_nxt = ST_IDLE;
      default:    st_nxt = ST_IDLE;
    endcase
  end

  // control state and voice tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      cnt_r        <= '0;
      fcnt_r       <= CW'(VOICES);
      act_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < VOICES; i++) begin
        fstack_r[i] <= VW'(VOICES - 1 - i);
        ident_r[i]  <= '0;
        vel_r[i]    <= '0;
        expr_r[i]   <= '0;
        prio_r[i]   <= '0;
        note_r[i]   <= '0;
      end
    end else begin
      st_r <= st_nxt;

      if (st_r == ST_DECODE && cur_r.kind == KIND_KEY_ON && !hit_any) begin
        if (fcnt_r != '0) begin
          fcnt_r <= fcnt_r - 1'b1;
        end else if (cnt_r != '0) begin
          // steal the lowest-priority voice at the head of the list
          cnt_r <= cnt_r - 1'b1;
          act_r[order_r[0]] <= 1'b0;
        end
      end
      if (st_r == ST_DECODE && cur_r.kind == KIND_KEY_OFF && hit_any) begin
        cnt_r          <= cnt_r - 1'b1;
        act_r[hit_idx] <= 1'b0;
        if (fcnt_r < CW'(VOICES)) begin
          fstack_r[fcnt_r[VW-1:0]] <= hit_idx;
          fcnt_r                   <= fcnt_r + 1'b1;
        end
      end
      if (st_r == ST_INSERT) begin
        cnt_r      <= cnt_r + 1'b1;
        act_r[v_r] <= 1'b1;
      end
      if (st_r == ST_STORE) begin
        ident_r[v_r] <= cur_r.voice_id;
        vel_r[v_r]   <= cur_r.velocity;
        expr_r[v_r]  <= cur_r.expression;
        prio_r[v_r]  <= prio_new;
        note_r[v_r]  <= cur_r.note;
      end
      if (st_r == ST_SCAN && pos_r < cnt_r && scan_hit && cur_r.kind == KIND_EXPR) begin
        expr_r[scan_v] <= cur_r.expression;
      end

      if (emit_fire) begin
        pend_valid_r <= 1'b1;
      end else if (mv_last) begin
        pend_valid_r <= 1'b0;
      end
      if (mv_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload, list order and datapath registers
  always_ff @(posedge clk) begin
    if (head_pop) begin
      cur_r <= head.item;
    end
    if (st_r == ST_DECODE) begin
      pos_r <= '0;
      if (cur_r.kind == KIND_KEY_ON) begin
        if (hit_any) begin
          v_r <= hit_idx;
        end else if (fcnt_r != '0) begin
          v_r <= fstack_r[VW'(fcnt_r - 1'b1)];
        end else if (cnt_r != '0) begin
          v_r <= order_r[0];
          for (int i = 0; i + 1 < VOICES; i++) begin
            order_r[i] <= order_r[i+1];
          end
        end
      end else if (cur_r.kind == KIND_KEY_OFF && hit_any) begin
        v_r <= hit_idx;
        for (int i = 0; i + 1 < VOICES; i++) begin
          if (VW'(i) >= opos) begin
            order_r[i] <= order_r[i+1];
          end
        end
      end
    end
    if (st_r == ST_FINDPOS && pos_adv) begin
      pos_r <= pos_r + 1'b1;
    end
    if (st_r == ST_INSERT) begin
      for (int i = 0; i < VOICES; i++) begin
        if (CW'(i) == pos_r) begin
          order_r[i] <= v_r;
        end
      end
      for (int i = 1; i < VOICES; i++) begin
        if (CW'(i) > pos_r) begin
          order_r[i] <= order_r[i-1];
        end
      end
    end
    if (st_r == ST_SCAN && pos_r < cnt_r) begin
      pos_r <= pos_r + 1'b1;
      if (scan_hit) begin
        v_r <= scan_v;
      end
    end
    if (st_r == ST_TONE_A) begin
      pa_r  <= PERIOD_TABLE[idx];
      pb_r  <= PERIOD_TABLE[nb];
      det_r <= biased[F-1:0];
    end
    if (st_r == ST_TONE_B) begin
      prod_a_r <= PW'(wa * pa_r);
      prod_b_r <= PW'(det_r * pb_r);
    end
    if (st_r == ST_LO) begin
      dp_hi_r <= dp[15:8];
    end
    if (emit_fire) begin
      pend_r <= emit_w;
    end
    if (mv_out) begin
      out_r.chip           <= pend_r.chip;
      out_r.register_index <= pend_r.register_index;
      out_r.write_data     <= pend_r.write_data;
      out_r.last           <= mv_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_write = out_r;

endmodule

/* src/psg_voice_allocator.sv */
// Top level of the voice allocator: event queue front end and write engine.
//
// Usage: note events enter on in_ch (valid/ready); each accepted beat is one
// key-on, key-off, expression or pitch-bend event. Register writes for two
// three-channel sound chips leave on out_ch, one write per beat, and the
// final write caused by an event carries last=1. Events that cause no write
// (drum-channel key-ons, unknown key-offs, unmatched channel events) leave
// nothing on out_ch.
// Sequencing: an event waits in a two-entry queue; the engine then runs
// DECODE, STORE, TONE_A, TONE_B, LO, HI, VOL and FINISH for a key-on that
// reuses its voice, and adds FINDPOS, which walks the list to find the insert
// position, and INSERT for one that takes a free or stolen voice. A key-off
// that hits runs DECODE, VOL and FINISH. Channel events run DECODE, then SCAN
// over the active voices, with TONE_A, TONE_B, LO and HI per matching voice for
// a bend or VOL for an expression, then FINISH. The period interpolation is two-stage.
// Reset: all voices free (voice 0 popped first), no active voices.
// Stalls: when out_ch is not ready, the engine holds its current write and
// stops; the front queue keeps taking events until it is full.
module psg_voice_allocator #(
  parameter int unsigned VOICES          = 6,
  parameter int unsigned VOICES_PER_CHIP = 3,
  parameter int unsigned FRACTION_BITS   = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  psgva_in_if.sink    in_ch,
  psgva_out_if.source out_ch
);
  import psgva_pkg::*;

  item_t       in_item;
  queue_head_t head;
  logic        head_pop;
  write_t      wr;

  // pack the event fields into one queue entry
  assign in_item.kind       = kind_t'(in_ch.kind);
  assign in_item.voice_id   = in_ch.voice_id;
  assign in_item.note       = in_ch.note;
  assign in_item.velocity   = in_ch.velocity;
  assign in_item.expression = in_ch.expression;
  assign in_item.bend       = in_ch.bend;

  psgva_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .head     (head),
    .head_pop (head_pop)
  );

  psgva_engine #(
    .VOICES          (VOICES),
    .VOICES_PER_CHIP (VOICES_PER_CHIP),
    .FRACTION_BITS   (FRACTION_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .head_pop  (head_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_write (wr)
  );

  // drive the write beat
  assign out_ch.chip           = wr.chip;
  assign out_ch.register_index = wr.register_index;
  assign out_ch.write_data     = wr.write_data;
  assign out_ch.last           = wr.last;

endmodule
